// ----- rtl/qmr_pkg.sv -----
// Shared types and constants for the quaternion multiply/rotate unit.
package qmr_pkg;

  localparam int COMP_WIDTH = 16;
  localparam int FRAC_BITS  = 14;
  localparam int OPND_WIDTH = COMP_WIDTH + 1;      // holds an exact negated component
  localparam int PROD_WIDTH = COMP_WIDTH + OPND_WIDTH;
  localparam int ACC_WIDTH  = PROD_WIDTH + 2;      // sum of four products

  typedef logic signed [COMP_WIDTH-1:0] comp_t;
  typedef logic signed [OPND_WIDTH-1:0] opnd_t;
  typedef comp_t [3:0] quat_t;

  localparam comp_t COMP_MAX = comp_t'({1'b0, {(COMP_WIDTH-1){1'b1}}});
  localparam comp_t COMP_MIN = comp_t'({1'b1, {(COMP_WIDTH-1){1'b0}}});

  typedef enum logic [1:0] {
    CMD_PRODUCT = 2'd0,
    CMD_ROTATE  = 2'd1,
    CMD_CONJ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  // Travels alongside an item through a multiply pass.
  typedef struct packed {
    cmd_t        cmd;
    quat_t       a;
    quat_t       mid;
    logic [3:0]  msat;
  } side_t;

endpackage

// ----- rtl/quaternion_multiply_rotate.sv -----
// Top level of the quaternion multiply/rotate unit.
// Takes one command per clock: busy is always low, so every cycle with start high is a
// transfer. Each result comes out_valid in issue order, for one cycle only; the receiver
// must take it then. The pipeline is an input register, two three-stage Hamilton passes
// (16 parallel multipliers, four-way sum, round and saturate), the second pass applying
// conj(a) for rotation, and an output register.
module quaternion_multiply_rotate import qmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] in_command,
  input  comp_t      in_a_w,
  input  comp_t      in_a_x,
  input  comp_t      in_a_y,
  input  comp_t      in_a_z,
  input  comp_t      in_b_w,
  input  comp_t      in_b_x,
  input  comp_t      in_b_y,
  input  comp_t      in_b_z,
  output logic       out_valid,
  output comp_t      out_r_w,
  output comp_t      out_r_x,
  output comp_t      out_r_y,
  output comp_t      out_r_z,
  output logic       out_saturated
);

  logic  s0_valid_r;
  cmd_t  s0_cmd_r;
  quat_t s0_a_r, s0_b_r;

  comp_t p1 [4];
  opnd_t q1 [4];
  side_t side1_in, side1_out, side2_in, side2_out;
  logic  v1_out, v2_out;
  comp_t r1 [4];
  comp_t r2 [4];
  logic [3:0] sat1, sat2;
  comp_t p2 [4];
  opnd_t q2 [4];

  quat_t res_nxt, res_r;
  logic  sat_nxt, sat_r;
  logic  out_valid_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else begin
      s0_valid_r <= start;
    end
  end

  always_ff @(posedge clk) begin
    s0_cmd_r <= cmd_t'(in_command);
    s0_a_r   <= {in_a_z, in_a_y, in_a_x, in_a_w};
    s0_b_r   <= {in_b_z, in_b_y, in_b_x, in_b_w};
  end

  // First pass: a * b, or a * (0, v) for rotation.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p1[k] = s0_a_r[k];
      q1[k] = opnd_t'(s0_b_r[k]);
    end
    if (s0_cmd_r == CMD_ROTATE) begin
      q1[0] = '0;
    end
    side1_in.cmd  = s0_cmd_r;
    side1_in.a    = s0_a_r;
    side1_in.mid  = '0;
    side1_in.msat = '0;
  end

  qmr_ham_pipe u_pass1 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (s0_valid_r),
    .p        (p1),
    .q        (q1),
    .side_in  (side1_in),
    .out_valid(v1_out),
    .r        (r1),
    .sat      (sat1),
    .side_out (side1_out)
  );

  // Second pass: mid * conj(a), conj kept exact in the wider operand.
  always_comb begin
    side2_in      = side1_out;
    side2_in.msat = sat1;
    for (int k = 0; k < 4; k++) begin
      side2_in.mid[k] = r1[k];
      p2[k]           = r1[k];
    end
    q2[0] = opnd_t'(side1_out.a[0]);
    for (int k = 1; k < 4; k++) begin
      q2[k] = -opnd_t'(side1_out.a[k]);
    end
  end

  qmr_ham_pipe u_pass2 (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (v1_out),
    .p        (p2),
    .q        (q2),
    .side_in  (side2_in),
    .out_valid(v2_out),
    .r        (r2),
    .sat      (sat2),
    .side_out (side2_out)
  );

  always_comb begin
    res_nxt = '0;
    sat_nxt = 1'b0;
    unique case (side2_out.cmd)
      CMD_PRODUCT: begin
        res_nxt = side2_out.mid;
        sat_nxt = |side2_out.msat;
      end
      CMD_ROTATE: begin
        for (int k = 1; k < 4; k++) begin
          res_nxt[k] = r2[k];
        end
        // final scalar part is discarded and does not flag
        sat_nxt = (|side2_out.msat) | (|sat2[3:1]);
      end
      CMD_CONJ: begin
        res_nxt[0] = side2_out.a[0];
        for (int k = 1; k < 4; k++) begin
          if (side2_out.a[k] == COMP_MIN) begin
            res_nxt[k] = COMP_MAX;
            sat_nxt    = 1'b1;
          end else begin
            res_nxt[k] = -side2_out.a[k];
          end
        end
      end
      default: begin
        res_nxt = '0;
        sat_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= v2_out;
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    sat_r <= sat_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_r_w       = res_r[0];
  assign out_r_x       = res_r[1];
  assign out_r_y       = res_r[2];
  assign out_r_z       = res_r[3];
  assign out_saturated = sat_r;

endmodule

// ----- rtl/qmr_ham_pipe.sv -----
// Three-stage Hamilton product pass: multiply, sum, round and saturate.
module qmr_ham_pipe import qmr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  comp_t      p [4],
  input  opnd_t      q [4],
  input  side_t      side_in,
  output logic       out_valid,
  output comp_t      r [4],
  output logic [3:0] sat,
  output side_t      side_out
);

  typedef logic signed [PROD_WIDTH-1:0] prod_t;
  typedef logic signed [ACC_WIDTH-1:0]  acc_t;
  typedef logic signed [ACC_WIDTH:0]    rnd_acc_t;

  typedef struct packed {
    comp_t val;
    logic  sat;
  } rnd_t;

  localparam rnd_acc_t HALF = rnd_acc_t'({{ACC_WIDTH{1'b0}}, 1'b1} << (FRAC_BITS - 1));

  // Add half an LSB, floor-shift, clamp to the component range.
  function automatic rnd_t round_sat(acc_t acc);
    rnd_acc_t                       t;
    rnd_acc_t                       sh;
    logic [ACC_WIDTH-COMP_WIDTH+1:0] hi;
    rnd_t                           res;
    t  = rnd_acc_t'(acc) + HALF;
    sh = t >>> FRAC_BITS;
    hi = sh[ACC_WIDTH:COMP_WIDTH-1];
    if ((&hi) || !(|hi)) begin
      res.val = sh[COMP_WIDTH-1:0];
      res.sat = 1'b0;
    end else begin
      res.val = sh[ACC_WIDTH] ? COMP_MIN : COMP_MAX;
      res.sat = 1'b1;
    end
    return res;
  endfunction

  logic  v1_r, v2_r, v3_r;
  side_t side1_r, side2_r, side3_r;
  prod_t prod_r   [4][4];
  prod_t prod_nxt [4][4];
  acc_t  acc_r    [4];
  acc_t  acc_nxt  [4];
  comp_t r_r      [4];
  comp_t r_nxt    [4];
  logic [3:0] sat_r, sat_nxt;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        prod_nxt[i][j] = prod_t'(p[i]) * prod_t'(q[j]);
      end
    end
  end

  always_comb begin
    acc_nxt[0] = acc_t'(prod_r[0][0]) - acc_t'(prod_r[1][1])
               - acc_t'(prod_r[2][2]) - acc_t'(prod_r[3][3]);
    acc_nxt[1] = acc_t'(prod_r[0][1]) + acc_t'(prod_r[1][0])
               + acc_t'(prod_r[2][3]) - acc_t'(prod_r[3][2]);
    acc_nxt[2] = acc_t'(prod_r[0][2]) + acc_t'(prod_r[2][0])
               + acc_t'(prod_r[3][1]) - acc_t'(prod_r[1][3]);
    acc_nxt[3] = acc_t'(prod_r[0][3]) + acc_t'(prod_r[3][0])
               + acc_t'(prod_r[1][2]) - acc_t'(prod_r[2][1]);
  end

  always_comb begin
    rnd_t rr;
    for (int k = 0; k < 4; k++) begin
      rr         = round_sat(acc_r[k]);
      r_nxt[k]   = rr.val;
      sat_nxt[k] = rr.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    prod_r  <= prod_nxt;
    acc_r   <= acc_nxt;
    r_r     <= r_nxt;
    sat_r   <= sat_nxt;
    side1_r <= side_in;
    side2_r <= side1_r;
    side3_r <= side2_r;
  end

  assign out_valid = v3_r;
  assign r         = r_r;
  assign sat       = sat_r;
  assign side_out  = side3_r;

endmodule

// ----- rtl/qmr_checker.sv -----
// Port-level checks for the quaternion multiply/rotate unit, bound to the top level.
module qmr_checker import qmr_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic [1:0] in_command,
  input comp_t      in_a_w,
  input logic       out_valid,
  input comp_t      out_r_w
);

  // every transfer yields its result
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##8 out_valid)
    else $error("result missing 8 cycles after transfer");

  // no result without a transfer that caused it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, 8))
    else $error("result without matching transfer");

  a_rotate_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && (in_command == CMD_ROTATE), 8)) |-> (out_r_w == '0))
    else $error("rotation scalar part not zero");

  a_conj_w: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(start && (in_command == CMD_CONJ), 8)) |->
      (out_r_w == $past(in_a_w, 8)))
    else $error("conjugate scalar part changed");

endmodule

bind quaternion_multiply_rotate qmr_checker u_qmr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_command(in_command),
  .in_a_w    (in_a_w),
  .out_valid (out_valid),
  .out_r_w   (out_r_w)
);
